// ===== src/svip_pkg.sv =====
// shared types, codes, pitch table and pitch/gain functions for the sampler voice
package svip_pkg;

    localparam int MIX_W   = 24;
    localparam int STEP_W  = 24;
    localparam int GAIN_W  = 17;
    localparam int POS_W   = 32;
    localparam int RATIO_W = 22;
    localparam int RATE_W  = 18;
    localparam int LEN_W   = 17;
    localparam int CHAN_W  = 2;
    localparam int NOTE_W  = 7;
    localparam int ADDR_W  = 16;
    localparam int CFG_W   = 18;
    localparam int CFGI_W  = 2;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    localparam logic [CFGI_W-1:0] CFG_RATE_RATIO      = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_SAMPLE_LENGTH   = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_SOURCE_CHANNELS = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_RD1,
        S_INTERP,
        S_GAIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic interp_en;
        logic gain_en;
        logic use_voice;
    } lane_ctl_t;

    localparam logic [RATE_W-1:0] RATE_RESET  = 18'd65536;
    localparam logic [LEN_W-1:0]  LEN_MAX     = 17'd65536;
    localparam logic [CHAN_W-1:0] CHAN_MONO   = 2'd1;
    localparam logic [CHAN_W-1:0] CHAN_STEREO = 2'd2;
    localparam logic [STEP_W-1:0] STEP_RESET  = 24'd65536;
    localparam logic [STEP_W-1:0] STEP_MAX    = 24'hFFFFFF;

    // 2^(k/12) in q16 for one octave
    localparam logic [16:0] SEMITONE_Q16 [12] = '{
        17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
        17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    function automatic logic [3:0] octave_of(input logic [NOTE_W-1:0] note);
        logic [3:0] oct;
        oct = '0;
        for (int i = 1; i <= 10; i++) begin
            if (note >= 7'(12 * i))
                oct = oct + 4'd1;
        end
        return oct;
    endfunction

    // pitch ratio relative to note 60 in q16: the octave shift is taken back down by 2^5
    function automatic logic [RATIO_W-1:0] ratio_of(input logic [NOTE_W-1:0] note);
        logic [3:0]  oct;
        logic [3:0]  semi;
        logic [27:0] shifted;
        oct     = octave_of(note);
        semi    = 4'(note - 7'(oct) * 7'd12);
        shifted = 28'(SEMITONE_Q16[semi]) << oct;
        return RATIO_W'((shifted + 28'd16) >> 5);
    endfunction

    // velocity * 65536 / 127 rounded; 65536 = 127 * 516 + 4
    function automatic logic [GAIN_W-1:0] gain_of(input logic [NOTE_W-1:0] vel);
        logic [9:0] r;
        logic [2:0] q;
        r = {1'b0, vel, 2'b00} + 10'd63;
        q = 3'(r >= 10'd127) + 3'(r >= 10'd254) + 3'(r >= 10'd381) + 3'(r >= 10'd508);
        return GAIN_W'(vel) * 17'd516 + GAIN_W'(q);
    endfunction

endpackage

// ===== src/svip_lane.sv =====
// one channel of the voice datapath: interpolate, apply gain, round, mix and saturate
module svip_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  svip_pkg::lane_ctl_t                ctl,
    input  logic signed [SAMPLE_BITS-1:0]      s0,
    input  logic signed [SAMPLE_BITS-1:0]      s1,
    input  logic [15:0]                        frac,
    input  logic [svip_pkg::GAIN_W-1:0]        gain,
    input  logic signed [svip_pkg::MIX_W-1:0]  mix,
    output logic signed [svip_pkg::MIX_W-1:0]  mixed
);
    import svip_pkg::*;

    localparam int IW = SAMPLE_BITS + 17;
    localparam int TW = SAMPLE_BITS + 18;
    localparam int PW = IW + 18;
    localparam int SH = SAMPLE_BITS + 8;
    localparam int VW = 26;
    localparam logic signed [PW-1:0] HALF   = PW'(1) << (SH - 1);
    localparam logic signed [VW-1:0] SAT_HI = VW'(8388607);
    localparam logic signed [VW-1:0] SAT_LO = VW'(-8388608);

    logic signed [SAMPLE_BITS:0]  diff;
    logic signed [16:0]           frac_s;
    logic signed [TW-1:0]         term;
    logic signed [TW-1:0]         interp_full;
    logic signed [IW-1:0]         interp_next;
    logic signed [IW-1:0]         interp_reg;
    logic signed [PW-1:0]         prod_next;
    logic signed [PW-1:0]         prod_reg;
    logic signed [PW-1:0]         rounded;
    logic signed [PW-1:0]         shifted;
    logic signed [VW-1:0]         voice;
    logic signed [VW-1:0]         sum;

    always_comb
    begin
        diff        = (SAMPLE_BITS + 1)'(s1) - (SAMPLE_BITS + 1)'(s0);
        frac_s      = $signed({1'b0, frac});
        term        = TW'(diff) * TW'(frac_s);
        interp_full = TW'($signed({s0, 16'b0})) + term;
        // result lies between the two frames, so it fits the narrower width
        interp_next = IW'(interp_full);
        prod_next   = PW'(interp_reg) * PW'($signed({1'b0, gain}));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.interp_en)
        begin
            interp_reg <= interp_next;
        end
        if (ctl.gain_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        rounded = prod_reg + HALF;
        shifted = rounded >>> SH;
        voice   = VW'(shifted);
        sum     = VW'(mix) + (ctl.use_voice ? voice : VW'(0));
        if (sum > SAT_HI)
            mixed = MIX_W'(SAT_HI);
        else if (sum < SAT_LO)
            mixed = MIX_W'(SAT_LO);
        else
            mixed = MIX_W'(sum);
    end

endmodule

// ===== src/sample_voice_interpolating_player.sv =====
// sampler voice top level: sample store, voice state, control sequencer
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  in       | in_valid / in_stall       | action address data_left data_right note
//           |                           | velocity mix_left mix_right
//  out      | out_valid / out_stall     | out_left out_right still_playing
//  cfg      | cfg_write                 | cfg_index cfg_data
//
// load and stop beats complete as they are accepted; start registers the pitch ratio,
// then S_STEP multiplies and rounds the step. a tick on a playing voice reads two
// adjacent frames from the single-port store, then runs an interpolation and a gain
// multiply stage per channel. a tick on an idle or finished voice goes to S_OUT.
// the result register lets new beats in while a result waits; a tick holds in its
// last cycle while the previous result is still stalled. no clearing pass after reset.
module sample_voice_interpolating_player #(
    parameter int SAMPLE_DEPTH = 65536,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [svip_pkg::ADDR_W-1:0]         address,
    input  logic signed [SAMPLE_BITS-1:0]       data_left,
    input  logic signed [SAMPLE_BITS-1:0]       data_right,
    input  logic [svip_pkg::NOTE_W-1:0]         note,
    input  logic [svip_pkg::NOTE_W-1:0]         velocity,
    input  logic signed [svip_pkg::MIX_W-1:0]   mix_left,
    input  logic signed [svip_pkg::MIX_W-1:0]   mix_right,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [svip_pkg::MIX_W-1:0]   out_left,
    output logic signed [svip_pkg::MIX_W-1:0]   out_right,
    output logic                                still_playing,
    input  logic                                cfg_write,
    input  logic [svip_pkg::CFGI_W-1:0]         cfg_index,
    input  logic [svip_pkg::CFG_W-1:0]          cfg_data
);
    import svip_pkg::*;

    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam logic [32:0] DEPTH = 33'(SAMPLE_DEPTH);

    state_t                    state_reg;
    state_t                    state_next;

    logic [RATE_W-1:0]         rate_ratio_reg;
    logic [LEN_W-1:0]          sample_length_reg;
    logic [CHAN_W-1:0]         source_channels_reg;

    logic [POS_W-1:0]          pos_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic                      active_reg;
    logic [RATIO_W-1:0]        ratio_reg;

    logic                      out_valid_reg;
    logic signed [MIX_W-1:0]   out_left_reg;
    logic signed [MIX_W-1:0]   out_right_reg;
    logic                      still_reg;

    logic signed [MIX_W-1:0]   mix_l_reg;
    logic signed [MIX_W-1:0]   mix_r_reg;
    logic signed [SAMPLE_BITS-1:0] s0_l_reg;
    logic signed [SAMPLE_BITS-1:0] s0_r_reg;
    logic signed [SAMPLE_BITS-1:0] s1_l;
    logic signed [SAMPLE_BITS-1:0] s1_r;
    logic                      zero_reg;

    logic [2*SAMPLE_BITS-1:0]  store_mem [SAMPLE_DEPTH];
    logic [2*SAMPLE_BITS-1:0]  rdata_reg;

    logic                      accept;
    action_t                   act;
    logic [15:0]               ip;
    logic [16:0]               ip_next1;
    logic [LEN_W-1:0]          len;
    logic                      at_end;
    logic                      play;
    logic                      out_free;
    logic [16:0]               rd_idx;
    logic                      rd_oor;
    logic                      rd_issue;
    logic                      mem_we;
    logic                      tick_done;
    lane_ctl_t                 ctl_l;
    lane_ctl_t                 ctl_r;
    logic [39:0]               step_prod;
    logic [24:0]               step_wide;
    logic [STEP_W-1:0]         step_sat;
    logic [POS_W:0]            pos_sum;
    logic [POS_W-1:0]          pos_adv;
    logic signed [MIX_W-1:0]   lane_l_out;
    logic signed [MIX_W-1:0]   lane_r_out;

    always_comb
    begin
        accept   = in_valid && !in_stall;
        act      = action_t'(action);
        ip       = pos_reg[POS_W-1:16];
        ip_next1 = {1'b0, ip} + 17'd1;
        len      = (sample_length_reg > LEN_MAX) ? LEN_MAX : sample_length_reg;
        at_end   = ip_next1 >= len;
        play     = active_reg && !at_end;
        out_free = !out_valid_reg || !out_stall;
        rd_oor   = 33'(rd_idx) >= DEPTH;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (act)
                        ACT_START: state_next = S_STEP;
                        ACT_TICK:  state_next = play ? S_RD1 : S_OUT;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_STEP:   state_next = S_IDLE;
            S_RD1:    state_next = S_INTERP;
            S_INTERP: state_next = S_GAIN;
            S_GAIN:   state_next = S_OUT;
            S_OUT:    state_next = out_free ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall        = (state_reg != S_IDLE);
        rd_issue        = ((state_reg == S_IDLE) && accept && (act == ACT_TICK) && play)
                          || (state_reg == S_RD1);
        rd_idx          = (state_reg == S_RD1) ? ip_next1 : {1'b0, ip};
        mem_we          = (state_reg == S_IDLE) && accept && (act == ACT_LOAD)
                          && (33'(address) < DEPTH);
        tick_done       = (state_reg == S_OUT) && out_free;
        ctl_l.interp_en = (state_reg == S_INTERP);
        ctl_l.gain_en   = (state_reg == S_GAIN);
        ctl_l.use_voice = play;
        ctl_r.interp_en = (state_reg == S_INTERP);
        ctl_r.gain_en   = (state_reg == S_GAIN);
        ctl_r.use_voice = play && (source_channels_reg != CHAN_MONO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_ratio_reg      <= RATE_RESET;
            sample_length_reg   <= '0;
            source_channels_reg <= CHAN_STEREO;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RATE_RATIO:      rate_ratio_reg      <= cfg_data;
                CFG_SAMPLE_LENGTH:   sample_length_reg   <= LEN_W'(cfg_data);
                CFG_SOURCE_CHANNELS: source_channels_reg <= CHAN_W'(cfg_data);
                default:             ;
            endcase
        end
    end

    // sample store, left in the low half
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[AW'(address)] <= {data_right, data_left};
        end
        if (rd_issue && !rd_oor)
        begin
            rdata_reg <= store_mem[AW'(rd_idx)];
        end
    end

    always_comb
    begin
        step_prod = 40'(ratio_reg) * 40'(rate_ratio_reg);
        step_wide = 25'((41'(step_prod) + 41'd32768) >> 16);
        step_sat  = step_wide[24] ? STEP_MAX : step_wide[STEP_W-1:0];
        pos_sum   = {1'b0, pos_reg} + (POS_W + 1)'(step_reg);
        pos_adv   = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
        s1_l      = zero_reg ? '0 : rdata_reg[SAMPLE_BITS-1:0];
        s1_r      = zero_reg ? '0 : rdata_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end

    // voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            step_reg   <= STEP_RESET;
            gain_reg   <= '0;
            active_reg <= 1'b0;
        end
        else if ((state_reg == S_IDLE) && accept && (act == ACT_STOP))
        begin
            pos_reg    <= '0;
            step_reg   <= STEP_RESET;
            gain_reg   <= '0;
            active_reg <= 1'b0;
        end
        else if ((state_reg == S_IDLE) && accept && (act == ACT_START))
        begin
            gain_reg <= gain_of(velocity);
        end
        else if (state_reg == S_STEP)
        begin
            pos_reg    <= '0;
            step_reg   <= step_sat;
            active_reg <= 1'b1;
        end
        else if (tick_done && active_reg)
        begin
            if (at_end)
            begin
                pos_reg    <= '0;
                step_reg   <= STEP_RESET;
                gain_reg   <= '0;
                active_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tick_done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && accept)
        begin
            ratio_reg <= ratio_of(note);
            mix_l_reg <= mix_left;
            mix_r_reg <= mix_right;
        end
        if (rd_issue)
        begin
            zero_reg <= rd_oor;
        end
        if (state_reg == S_RD1)
        begin
            s0_l_reg <= s1_l;
            s0_r_reg <= s1_r;
        end
        if (tick_done)
        begin
            out_left_reg  <= lane_l_out;
            out_right_reg <= lane_r_out;
            still_reg     <= play;
        end
    end

    svip_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .clk   (clk),
        .ctl   (ctl_l),
        .s0    (s0_l_reg),
        .s1    (s1_l),
        .frac  (pos_reg[15:0]),
        .gain  (gain_reg),
        .mix   (mix_l_reg),
        .mixed (lane_l_out)
    );

    svip_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .clk   (clk),
        .ctl   (ctl_r),
        .s0    (s0_r_reg),
        .s1    (s1_r),
        .frac  (pos_reg[15:0]),
        .gain  (gain_reg),
        .mix   (mix_r_reg),
        .mixed (lane_r_out)
    );

    assign out_valid     = out_valid_reg;
    assign out_left      = out_left_reg;
    assign out_right     = out_right_reg;
    assign still_playing = still_reg;

endmodule

// ===== src/svip_checker.sv =====
// port-level checks for the sampler voice, bound to the top level
module svip_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic [1:0]                         action,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [svip_pkg::MIX_W-1:0]  out_left,
    input logic signed [svip_pkg::MIX_W-1:0]  out_right,
    input logic                               still_playing
);
    import svip_pkg::*;

    // the input side only blocks after it took a beat
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("in_stall rose without an accepted beat");

    // a tick always keeps the sequencer busy for the next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action == ACT_TICK)) |=> in_stall)
        else $error("tick accepted but input not stalled next cycle");

    // results are only produced while a tick is in flight
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no tick in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_left)
            && $stable(out_right) && $stable(still_playing)))
        else $error("stalled result beat changed");

endmodule

bind sample_voice_interpolating_player svip_checker u_svip_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left      (out_left),
    .out_right     (out_right),
    .still_playing (still_playing)
);
